@@ src/u8ns_pkg.sv @@
// Shared types and constants for the UTF-8 validating name sanitizer.
// Used by u8ns_step and utf8_validating_name_sanitizer_core; no dependencies.
package u8ns_pkg;

    // Lead byte ranges and byte classes.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [1:0] CONT_TAG    = 2'b10;
    localparam logic [7:0] CTRL_LIMIT  = 8'd32;
    localparam logic [7:0] DEL_CHAR    = 8'd127;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] TERM_CHAR   = 8'h00;

    // Code point limits.
    localparam logic [20:0] MIN_CP2   = 21'h00080;
    localparam logic [20:0] MIN_CP3   = 21'h00800;
    localparam logic [20:0] MIN_CP4   = 21'h10000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h0D800;
    localparam logic [20:0] SURR_HI   = 21'h0DFFF;

    // Result kinds carried on tuser.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Capacity register reset value.
    localparam logic [10:0] CAP_RESET = 11'd64;

    // Per-string decoder state.
    typedef struct packed {
        logic [2:0][7:0] held;
        logic [2:0]      exp_len;
        logic [2:0]      rcv;
        logic [20:0]     cp;
        logic [10:0]     used;
        logic            full;
        logic            err;
    } u8ns_state_t;

    // Results caused by one input byte: up to four name bytes or one status.
    typedef struct packed {
        logic [2:0]      cnt;
        logic            kind;
        logic [3:0][7:0] bytes;
        logic            valid;
        logic [9:0]      used;
    } u8ns_res_t;

endpackage

@@ src/u8ns_step.sv @@
// Per-byte UTF-8 decode, check and emit logic (combinational).
// Depends on u8ns_pkg for the state and result types.
module u8ns_step #(
    parameter int MAX_CAPACITY = 1024
) (
    input  logic [7:0]           in_byte,
    input  logic [10:0]          capacity,
    input  u8ns_pkg::u8ns_state_t cur,
    output u8ns_pkg::u8ns_state_t nxt,
    output u8ns_pkg::u8ns_res_t   res
);
    import u8ns_pkg::*;

    localparam logic [16:0] MaxCap = 17'(MAX_CAPACITY);

    logic [16:0] lim;
    logic        fin;
    logic [2:0]  fin_len;
    logic [20:0] fin_cp;
    logic [20:0] cp_acc;
    logic [2:0]  rcv_inc;
    logic [7:0]  san;
    logic [7:0]  last;
    logic        bad;
    logic        fit;

    always_comb begin
        nxt     = cur;
        res     = '0;
        fin     = 1'b0;
        fin_len = 3'd0;
        fin_cp  = '0;
        cp_acc  = {cur.cp[14:0], in_byte[5:0]};
        rcv_inc = cur.rcv + 3'd1;
        lim     = ({6'd0, capacity} > MaxCap) ? MaxCap : {6'd0, capacity};

        // Control characters and DEL go out as a space.
        san  = (in_byte < CTRL_LIMIT || in_byte == DEL_CHAR) ? SPACE_CHAR : in_byte;

        if (in_byte == TERM_CHAR) begin
            // End of string: one status result and a fresh state.
            res.cnt   = 3'd1;
            res.kind  = KIND_STATUS;
            res.valid = !cur.err && (cur.exp_len == 3'd0);
            res.used  = cur.used[9:0];
            nxt       = '0;
        end else if (!cur.err) begin
            if (cur.exp_len == 3'd0) begin
                // Lead byte.
                nxt.rcv     = 3'd1;
                nxt.held[0] = in_byte;
                if (in_byte < ASCII_LIMIT) begin
                    fin     = 1'b1;
                    fin_len = 3'd1;
                    fin_cp  = {13'd0, in_byte};
                end else if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX) begin
                    nxt.exp_len = 3'd2;
                    nxt.cp      = {16'd0, in_byte[4:0]};
                end else if (in_byte >= LEAD3_MIN && in_byte <= LEAD3_MAX) begin
                    nxt.exp_len = 3'd3;
                    nxt.cp      = {17'd0, in_byte[3:0]};
                end else if (in_byte >= LEAD4_MIN && in_byte <= LEAD4_MAX) begin
                    nxt.exp_len = 3'd4;
                    nxt.cp      = {18'd0, in_byte[2:0]};
                end else begin
                    nxt.exp_len = 3'd0;
                    nxt.rcv     = 3'd0;
                    nxt.err     = 1'b1;
                end
            end else if (in_byte[7:6] != CONT_TAG) begin
                // A sequence broken by a non-continuation byte.
                nxt.err     = 1'b1;
                nxt.exp_len = 3'd0;
                nxt.rcv     = 3'd0;
                nxt.cp      = '0;
            end else begin
                // Continuation byte.
                nxt.cp  = cp_acc;
                nxt.rcv = rcv_inc;
                if (cur.rcv < 3'd3) begin
                    nxt.held[cur.rcv[1:0]] = in_byte;
                end
                if (rcv_inc >= cur.exp_len) begin
                    fin     = 1'b1;
                    fin_len = cur.exp_len;
                    fin_cp  = cp_acc;
                end
            end
        end

        // Completed character: range checks, then fit against the buffer.
        bad = (fin_len == 3'd2 && fin_cp < MIN_CP2) ||
              (fin_len == 3'd3 && fin_cp < MIN_CP3) ||
              (fin_len == 3'd4 && fin_cp < MIN_CP4) ||
              (fin_cp > MAX_CP) ||
              (fin_cp >= SURR_LO && fin_cp <= SURR_HI);
        fit  = ({6'd0, cur.used} + {14'd0, fin_len}) < lim;
        last = (fin_len == 3'd1) ? san : in_byte;

        if (fin) begin
            nxt.exp_len = 3'd0;
            nxt.rcv     = 3'd0;
            nxt.cp      = '0;
            if (bad) begin
                nxt.err = 1'b1;
            end else if (cur.full || !fit) begin
                nxt.full = 1'b1;
            end else begin
                res.cnt      = fin_len;
                res.kind     = KIND_BYTE;
                res.bytes[0] = (fin_len == 3'd1) ? last : cur.held[0];
                res.bytes[1] = (fin_len == 3'd2) ? last : cur.held[1];
                res.bytes[2] = (fin_len == 3'd3) ? last : cur.held[2];
                res.bytes[3] = last;
                nxt.used     = cur.used + {8'd0, fin_len};
            end
        end
    end

endmodule

@@ src/utf8_validating_name_sanitizer_core.sv @@
// Top level of the UTF-8 validating name sanitizer: state, config and output buffer.
// Depends on u8ns_pkg and u8ns_step.
//
//   Channel   Ports           Moves
//   -------   -------------   ------------------------------------------------
//   input     s_axis (s_*)    one string byte per request, zero ends a string
//   result    m_axis (m_*)    name byte or end-of-string status per request
//   config    cfg_we/wdata    capacity register, written on cfg_we
//
// Each byte is decoded and checked combinationally; its results (one to four name
// bytes, or one status) are loaded into an output group register and leave at
// one per cycle while m_tready is high. A byte is taken whenever the group
// register is empty or sends its last result in the same cycle, so ASCII streams
// run at one byte per cycle when unstalled; a fitting 4-byte character yields
// four results. Reset is synchronous on aresetn low and clears all string state;
// capacity returns to 64. A stalled m_tready holds the group register and s_tready.
module utf8_validating_name_sanitizer_core #(
    parameter int MAX_CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,     // capacity
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] in_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [7:0] out_byte, [8] name_valid,
                                       // [18:9] bytes_used, [23:19] zero
    output logic        m_tlast,       // run_last
    output logic [0:0]  m_tuser        // [0] item_kind
);
    import u8ns_pkg::*;

    logic [10:0]     cap_reg;
    u8ns_state_t     st_reg;
    u8ns_state_t     st_next;
    u8ns_res_t       res;

    logic            busy_reg;
    logic [1:0]      cnt_reg;
    logic [1:0]      idx_reg;
    logic            kind_reg;
    logic [3:0][7:0] bytes_reg;
    logic            valid_reg;
    logic [9:0]      used_reg;

    logic            pop;
    logic            last_pop;
    logic            accept;

    // Per-byte decode and check.
    u8ns_step #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_step (
        .in_byte (s_tdata),
        .capacity(cap_reg),
        .cur     (st_reg),
        .nxt     (st_next),
        .res     (res)
    );

    // Handshake control.
    assign pop      = busy_reg && m_tready;
    assign last_pop = pop && (idx_reg == cnt_reg);
    assign s_tready = !busy_reg || last_pop;
    assign accept   = s_tvalid && s_tready;

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Decoder state advances on every accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    // Output group: load on a byte with results, step through them as they leave.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            idx_reg  <= 2'd0;
        end else if (accept && res.cnt != 3'd0) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 2'(res.cnt - 3'd1);
            idx_reg  <= 2'd0;
        end else if (last_pop) begin
            busy_reg <= 1'b0;
        end else if (pop) begin
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    // Group payload.
    always_ff @(posedge aclk) begin
        if (accept && res.cnt != 3'd0) begin
            kind_reg  <= res.kind;
            bytes_reg <= res.bytes;
            valid_reg <= res.valid;
            used_reg  <= res.used;
        end
    end

    // Result stream outputs.
    assign m_tvalid = busy_reg;
    assign m_tdata  = {5'd0, used_reg, valid_reg, bytes_reg[idx_reg]};
    assign m_tlast  = (idx_reg == cnt_reg);
    assign m_tuser  = kind_reg;

endmodule

@@ verif/tb_utf8_validating_name_sanitizer_core.sv @@
// Testbench for utf8_validating_name_sanitizer_core: directed and random byte strings
// checked against an in-bench UTF-8 sanitizer predictor. Depends on u8ns_pkg and the
// core RTL only.
module tb_utf8_validating_name_sanitizer_core;
    import u8ns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CAP       = 1024;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CLAMP_BYTES   = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_LIMIT  = 10;

    // One expected result of the sanitizer.
    typedef struct packed {
        logic       kind;
        logic [7:0] name_char;
        logic       ok;
        logic [9:0] used;
        logic       tail;
    } name_item_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    // Predictor state: one copy of the register and the per-string decoder.
    logic [10:0]   cap_reg;
    logic [7:0]    held [3];
    int unsigned   open_len;
    int unsigned   got_cnt;
    logic [20:0]   cp_acc;
    int unsigned   sent_cnt;
    logic          is_full;
    logic          is_bad;

    name_item_t    sanitized_q [$];
    int            mismatches;
    int            result_idx;
    int            live_items;
    int            burst_left;
    int            cycle_cnt;
    int            stall_mode;
    int            mode_left;
    int            stall_left;
    name_item_t    want;
    logic          bad_field;

    utf8_validating_name_sanitizer_core #(
        .MAX_CAPACITY(MAX_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Run limit in case the block hangs or loses results.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver stalls: the pattern switches at random among four modes.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycle_cnt % 3 == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_idx++;
            if (sanitized_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR result %0d: none expected, got kind=%0b data=%06h last=%0b",
                             result_idx, m_tuser[0], m_tdata, m_tlast);
            end else begin
                want = sanitized_q.pop_front();
                bad_field = (m_tuser[0] !== want.kind) || (m_tdata[7:0] !== want.name_char) ||
                            (m_tdata[8] !== want.ok) || (m_tdata[18:9] !== want.used) ||
                            (m_tdata[23:19] !== 5'd0) || (m_tlast !== want.tail);
                if (bad_field) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $write("ERROR result %0d: expected kind=%0b char=%02h valid=%0b",
                               result_idx, want.kind, want.name_char, want.ok);
                        $display(" used=%0d last=%0b", want.used, want.tail);
                        $display("  got kind=%0b char=%02h valid=%0b used=%0d pad=%0h last=%0b",
                                 m_tuser[0], m_tdata[7:0], m_tdata[8], m_tdata[18:9],
                                 m_tdata[23:19], m_tlast);
                    end
                end
            end
        end
    end

    // Per-string state returns to zero at reset and after every terminator.
    function automatic void clear_string();
        held     = '{default: 8'h00};
        open_len = 0;
        got_cnt  = 0;
        cp_acc   = '0;
        sent_cnt = 0;
        is_full  = 1'b0;
        is_bad   = 1'b0;
    endfunction

    function automatic void push_name_char(input logic [7:0] ch, input logic tail);
        sanitized_q.push_back('{kind: KIND_BYTE, name_char: ch, ok: 1'b0, used: '0, tail: tail});
    endfunction

    // A character is complete: reject bad code points, then emit it if it fits.
    function automatic void close_char(input logic [7:0] last_char);
        int unsigned len;
        int unsigned lim;
        logic [20:0] pt;
        len      = open_len;
        pt       = cp_acc;
        lim      = {21'd0, cap_reg};
        open_len = 0;
        got_cnt  = 0;
        cp_acc   = '0;
        if ((len == 2 && pt < MIN_CP2) || (len == 3 && pt < MIN_CP3) ||
            (len == 4 && pt < MIN_CP4) || pt > MAX_CP || (pt >= SURR_LO && pt <= SURR_HI)) begin
            is_bad = 1'b1;
            return;
        end
        if (lim > MAX_CAP) lim = MAX_CAP;
        if (is_full || sent_cnt + len >= lim) begin
            is_full = 1'b1;
            return;
        end
        if (len == 1) begin
            push_name_char((pt < CTRL_LIMIT || pt == DEL_CHAR) ? SPACE_CHAR : pt[7:0], 1'b1);
            sent_cnt++;
            return;
        end
        for (int i = 0; i + 1 < len && i < 3; i++) push_name_char(held[i], 1'b0);
        push_name_char(last_char, 1'b1);
        sent_cnt += len;
    endfunction

    // Predict the results of one accepted input byte.
    function automatic void sanitize_byte(input logic [7:0] c);
        if (c == TERM_CHAR) begin
            sanitized_q.push_back('{kind: KIND_STATUS, name_char: 8'h00,
                                    ok: (!is_bad && open_len == 0), used: sent_cnt[9:0],
                                    tail: 1'b1});
            clear_string();
            return;
        end
        if (is_bad) return;
        if (open_len == 0) begin
            got_cnt = 1;
            held[0] = c;
            if (c < ASCII_LIMIT) begin
                open_len = 1;
                cp_acc   = 21'(c);
                close_char(c);
            end else if (c >= LEAD2_MIN && c <= LEAD2_MAX) begin
                open_len = 2;
                cp_acc   = 21'(c[4:0]);
            end else if (c >= LEAD3_MIN && c <= LEAD3_MAX) begin
                open_len = 3;
                cp_acc   = 21'(c[3:0]);
            end else if (c >= LEAD4_MIN && c <= LEAD4_MAX) begin
                open_len = 4;
                cp_acc   = 21'(c[2:0]);
            end else begin
                open_len = 0;
                got_cnt  = 0;
                is_bad   = 1'b1;
            end
            return;
        end
        if (c[7:6] != CONT_TAG) begin
            is_bad   = 1'b1;
            open_len = 0;
            got_cnt  = 0;
            cp_acc   = '0;
            return;
        end
        cp_acc = {cp_acc[14:0], c[5:0]};
        if (got_cnt < 3) held[got_cnt] = c;
        got_cnt++;
        if (got_cnt >= open_len) close_char(c);
    endfunction

    // Send one byte request, with a random gap before each new burst.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        live_items++;
        sanitize_byte(b);
    endtask

    task automatic send_bytes(input logic [7:0] seq_bytes [$]);
        foreach (seq_bytes[i]) send_byte(seq_bytes[i]);
    endtask

    // Stop sending and let all outstanding results drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sanitized_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [10:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cap_reg = value;
        cfg_we <= 1'b0;
    endtask

    // Encode a code point into n bytes, lead byte first; overlong and
    // out-of-range values are encoded just as well.
    function automatic logic [3:0][7:0] encode_char(input logic [20:0] cp, input int n);
        logic [3:0][7:0] enc;
        enc = '0;
        case (n)
            1: enc[0] = cp[7:0];
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {CONT_TAG, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {CONT_TAG, cp[11:6]};
                enc[2] = {CONT_TAG, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {CONT_TAG, cp[17:12]};
                enc[2] = {CONT_TAG, cp[11:6]};
                enc[3] = {CONT_TAG, cp[5:0]};
            end
        endcase
        return enc;
    endfunction

    function automatic logic [20:0] valid_cp(input int n);
        logic [20:0] cp;
        case (n)
            1: cp = 21'($urandom_range(1, 127));
            2: cp = 21'($urandom_range(MIN_CP2, MIN_CP3 - 1));
            3: begin
                cp = 21'($urandom_range(MIN_CP3, 21'h0FFFF));
                // Move surrogates up into the range F800 to FFFF.
                if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h02000;
            end
            default: cp = 21'($urandom_range(MIN_CP4, MAX_CP));
        endcase
        return cp;
    endfunction

    // Send the first count bytes of an encoded character.
    task automatic send_coded(input logic [3:0][7:0] enc, input int count);
        for (int i = 0; i < count; i++) send_byte(enc[i]);
    endtask

    task automatic send_good_char();
        int          pick;
        int          n;
        logic [20:0] cp;
        pick = $urandom_range(0, 8);
        if (pick <= 3) begin
            send_byte(8'($urandom_range(32, 126)));
        end else if (pick == 4) begin
            // Control characters and DEL turn into spaces.
            cp = 21'($urandom_range(1, 32));
            send_byte((cp == 32) ? DEL_CHAR : cp[7:0]);
        end else begin
            n = (pick <= 6) ? 2 : pick - 4;
            cp = valid_cp(n);
            send_coded(encode_char(cp, n), n);
        end
    endtask

    task automatic send_bad_char(input logic cut_off);
        int              n;
        int              k;
        logic [20:0]     cp;
        logic [3:0][7:0] enc;
        if (cut_off) begin
            // Partial multi-byte character; the terminator follows.
            n = $urandom_range(2, 4);
            send_coded(encode_char(valid_cp(n), n), $urandom_range(1, n - 1));
            return;
        end
        case ($urandom_range(0, 5))
            0: send_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                                     : 8'($urandom_range(8'hF5, 8'hFF)));
            1: begin
                // Overlong forms.
                n  = $urandom_range(3, 4);
                cp = (n == 3) ? 21'($urandom_range(0, MIN_CP3 - 1))
                              : 21'($urandom_range(0, MIN_CP4 - 1));
                send_coded(encode_char(cp, n), n);
            end
            2: send_coded(encode_char(21'($urandom_range(SURR_LO, SURR_HI)), 3), 3);
            3: send_coded(encode_char(21'($urandom_range(21'h110000, 21'h13FFFF)), 4), 4);
            4: begin
                // A continuation slot holds a byte without the continuation tag.
                n   = $urandom_range(2, 4);
                enc = encode_char(valid_cp(n), n);
                k   = $urandom_range(1, n - 1);
                enc[k] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 127))
                                                     : 8'($urandom_range(8'hC0, 8'hFF));
                send_coded(enc, n);
            end
            default: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
        endcase
    endtask

    // Mostly well-formed strings; one in five carries a fault somewhere.
    task automatic send_random_string();
        int   n_chars;
        int   err_pos;
        logic faulty;
        n_chars = $urandom_range(0, 10);
        faulty  = ($urandom_range(0, 4) == 0);
        err_pos = $urandom_range(0, n_chars);
        for (int i = 0; i < n_chars; i++) begin
            if (faulty && i == err_pos) send_bad_char(1'b0);
            else send_good_char();
        end
        if (faulty && err_pos == n_chars) send_bad_char(1'b1);
        send_byte(TERM_CHAR);
    endtask

    // Control characters, DEL, plain ASCII and the smallest and largest
    // multi-byte characters under the reset capacity.
    task automatic test_char_classes();
        logic [7:0] seq_bytes [$];
        seq_bytes = '{8'h01, 8'h7F, 8'h41, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, TERM_CHAR};
        send_bytes(seq_bytes);
    endtask

    // A surrogate followed by bytes that must be dropped, then a string cut
    // off inside a character.
    task automatic test_invalid_forms();
        logic [7:0] seq_bytes [$];
        seq_bytes = '{8'hED, 8'hA0, 8'h80, 8'h41, TERM_CHAR, 8'hC2, TERM_CHAR};
        send_bytes(seq_bytes);
    endtask

    // Capacity zero emits no name bytes; a small capacity truncates on a character boundary.
    task automatic test_capacity_limits();
        logic [7:0] seq_bytes [$];
        wait_idle();
        write_capacity(11'd0);
        seq_bytes = '{8'h41, TERM_CHAR};
        send_bytes(seq_bytes);
        wait_idle();
        write_capacity(11'd3);
        seq_bytes = '{8'h41, 8'hC3, 8'hA9, 8'h42, TERM_CHAR};
        send_bytes(seq_bytes);
    endtask

    // The capacity is changed while a character is half received.
    task automatic test_midstring_capacity();
        logic [7:0] seq_bytes [$];
        wait_idle();
        write_capacity(11'd2);
        seq_bytes = '{8'hE2, 8'h82};
        send_bytes(seq_bytes);
        wait_idle();
        write_capacity(11'd4);
        seq_bytes = '{8'hAC, TERM_CHAR};
        send_bytes(seq_bytes);
    endtask

    // A capacity above the maximum acts as the maximum, so a long string is not cut.
    task automatic test_capacity_clamp();
        wait_idle();
        write_capacity(11'd2047);
        repeat (CLAMP_BYTES) send_byte(8'($urandom_range(1, 127)));
        send_byte(TERM_CHAR);
    endtask

    // Random strings over a series of capacity settings.
    task automatic test_random_strings();
        logic [10:0] phase_caps [8];
        int          base;
        phase_caps = '{11'd64, 11'd1, 11'd2047, 11'd5, 11'd0, 11'd1024,
                       11'($urandom_range(0, 2047)), 11'($urandom_range(1, 40))};
        base = live_items;
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_capacity(phase_caps[p]);
            while (live_items - base < (p + 1) * RANDOM_ITEMS / 8) send_random_string();
        end
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        mismatches  = 0;
        result_idx  = 0;
        live_items  = 0;
        burst_left  = 0;
        cycle_cnt   = 0;
        stall_mode  = 0;
        mode_left   = 0;
        stall_left  = 0;
        cap_reg     = CAP_RESET;
        clear_string();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_char_classes();
        test_invalid_forms();
        test_capacity_limits();
        test_midstring_capacity();
        test_capacity_clamp();
        test_random_strings();
        wait_idle();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ utf8_validating_name_sanitizer_core.f @@
src/u8ns_pkg.sv
src/u8ns_step.sv
src/utf8_validating_name_sanitizer_core.sv
verif/tb_utf8_validating_name_sanitizer_core.sv
